/* sv/block_transfer_receiver_ring_macros.svh */
// assertion macros for the block transfer receiver checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BLOCK_TRANSFER_RECEIVER_RING_MACROS_SVH
`define BLOCK_TRANSFER_RECEIVER_RING_MACROS_SVH

// condition that holds at every edge out of reset
`define BTRR_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define BTRR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTRR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/btrr_pkg.sv */
// shared types and constants for the block transfer receiver
// no dependencies
package btrr_pkg;

  localparam int CMD_W       = 2;
  localparam int NUM_W       = 8;
  localparam int LEN_W       = 10;
  localparam int BYTE_W      = 8;
  localparam int FILL_W      = 13;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int CHUNK_BYTES = 512;

  typedef enum logic [CMD_W-1:0] {
    CMD_HEADER  = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  // one pending result, read byte not yet known
  typedef struct packed {
    kind_e             kind;
    logic              was_new;
    logic              read_valid;
    logic [FILL_W-1:0] fill;
  } result_t;

endpackage

/* sv/btrr_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module btrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/block_transfer_receiver_ring.sv */
// top level of the block transfer receiver with its byte ring
// depends on btrr_pkg and btrr_ram
//
// Takes one item per clock: a block header, a payload byte or a read request, selected by
// s_axis_tuser. Payload of each in-sequence block goes into a RING_BYTES deep byte ring held
// in one synchronous RAM; a read request removes the oldest byte. Pointers and fill count are
// updated in the cycle the item is accepted, so items can follow back to back with no gaps.
// A result (block acknowledgement or read reply) first goes into the p1 result slot, loaded
// as the ring RAM read is issued, then into the output register. Two result slots decouple
// the sides, so input is only held off when both are full and the output is stalled.
// The ring content needs no clearing after reset; only written bytes are ever read back.
module block_transfer_receiver_ring #(
  parameter int RING_BYTES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,     // no_overwrite
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // block_number[7:0], block_length[17:8], data_byte[25:18], zeros above
  input  logic [btrr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                            s_axis_tlast,    // final_block
  input  logic [btrr_pkg::CMD_W-1:0]      s_axis_tuser,    // command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // block_was_new[0], read_byte[8:1], read_valid[9], fill_level[22:10], zeros above
  output logic [btrr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser     // result_kind
);
  import btrr_pkg::*;

  localparam int PTR_W     = $clog2(RING_BYTES);
  localparam int CNT_W     = $clog2(RING_BYTES + 1);
  localparam int CHUNK_SAT = (CHUNK_BYTES > 1023) ? 1023 : CHUNK_BYTES;
  localparam logic [LEN_W-1:0] CHUNK_LIM = CHUNK_SAT[LEN_W-1:0];
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(RING_BYTES);

  // input fields
  cmd_e              cmd;
  logic [NUM_W-1:0]  in_number;
  logic [LEN_W-1:0]  in_length;
  logic [BYTE_W-1:0] in_byte;
  logic [LEN_W-1:0]  len_sat;

  // state
  logic              no_overwrite_q;
  logic              receiving_q, receiving_d;
  logic [NUM_W-1:0]  expected_q, expected_d;
  logic [PTR_W-1:0]  head_q, head_d, head_nxt;
  logic [PTR_W-1:0]  tail_q, tail_d, tail_nxt;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic              store_q, store_d;
  logic              final_q, final_d;

  // result path
  logic              accept;
  logic              res_load;
  result_t           res_new;
  logic              p1_valid_q, p1_valid_d;
  result_t           p1_res_q;
  logic              p1_advance;
  logic              out_valid_q, out_valid_d;
  result_t           out_res_q;
  logic [BYTE_W-1:0] out_byte_q;

  // ring ram
  logic              ram_we, ram_re;
  logic [BYTE_W-1:0] ram_rdata;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  assign cmd       = cmd_e'(s_axis_tuser);
  assign in_number = s_axis_tdata[NUM_W-1:0];
  assign in_length = s_axis_tdata[NUM_W+LEN_W-1:NUM_W];
  assign in_byte   = s_axis_tdata[NUM_W+LEN_W+BYTE_W-1:NUM_W+LEN_W];
  assign len_sat   = (in_length > CHUNK_LIM) ? CHUNK_LIM : in_length;

  assign head_nxt = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;

  assign p1_advance    = p1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !p1_valid_q || p1_advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // low bits of the new count, zero-extended for small rings
  assign fill_ext = {{FILL_W{1'b0}}, count_d};

  always_comb begin
    receiving_d = receiving_q;
    expected_d  = expected_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    left_d      = left_q;
    store_d     = store_q;
    final_d     = final_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    res_load    = 1'b0;
    res_new.kind       = KIND_ACK;
    res_new.was_new    = 1'b0;
    res_new.read_valid = 1'b0;
    res_new.fill       = '0;
    if (accept) begin
      case (cmd)
        CMD_HEADER: begin
          if (!receiving_q) begin
            receiving_d = 1'b1;
            expected_d  = NUM_W'(1);
            store_d     = 1'b1;
          end else if (in_number == expected_q + 1'b1) begin
            expected_d = expected_q + 1'b1;
            store_d    = 1'b1;
          end else begin
            store_d = 1'b0;
          end
          final_d = s_axis_tlast;
          left_d  = len_sat;
          if (len_sat == '0) begin
            res_load        = 1'b1;
            res_new.was_new = store_d;
            if (final_d) begin
              receiving_d = 1'b0;
            end
            store_d = 1'b0;
            final_d = 1'b0;
          end
        end
        CMD_PAYLOAD: begin
          if (left_q != '0) begin
            if (store_q) begin
              if (count_q == CNT_FULL) begin
                if (!no_overwrite_q) begin
                  // full ring: drop the oldest byte to make room
                  head_d = head_nxt;
                  tail_d = tail_nxt;
                  ram_we = 1'b1;
                end
              end else begin
                tail_d  = tail_nxt;
                count_d = count_q + 1'b1;
                ram_we  = 1'b1;
              end
            end
            left_d = left_q - 1'b1;
            if (left_d == '0) begin
              res_load        = 1'b1;
              res_new.was_new = store_q;
              if (final_q) begin
                receiving_d = 1'b0;
              end
              store_d = 1'b0;
              final_d = 1'b0;
            end
          end
        end
        CMD_READ: begin
          res_load     = 1'b1;
          res_new.kind = KIND_READ;
          if (count_q != '0) begin
            ram_re             = 1'b1;
            head_d             = head_nxt;
            count_d            = count_q - 1'b1;
            res_new.read_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res_new.fill = fill_ext[FILL_W-1:0];
  end

  always_comb begin
    p1_valid_d = p1_valid_q;
    if (res_load) begin
      p1_valid_d = 1'b1;
    end else if (p1_advance) begin
      p1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (p1_advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_overwrite_q <= 1'b0;
      receiving_q    <= 1'b0;
      expected_q     <= '0;
      head_q         <= '0;
      tail_q         <= '0;
      count_q        <= '0;
      left_q         <= '0;
      store_q        <= 1'b0;
      final_q        <= 1'b0;
      p1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        no_overwrite_q <= cfg_wdata_i;
      end
      receiving_q <= receiving_d;
      expected_q  <= expected_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      left_q      <= left_d;
      store_q     <= store_d;
      final_q     <= final_d;
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      p1_res_q <= res_new;
    end
    if (p1_advance) begin
      out_res_q  <= p1_res_q;
      // ram data holds until the next read, which needs this slot to move on
      out_byte_q <= p1_res_q.read_valid ? ram_rdata : '0;
    end
  end

  btrr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_BYTES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (in_byte),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tdata  = {1'b0, out_res_q.fill, out_res_q.read_valid, out_byte_q,
                          out_res_q.was_new};

endmodule

/* sv/btrr_checker.sv */
// port-level checks on the block transfer receiver, bound to the top level
// depends on btrr_pkg and block_transfer_receiver_ring_macros.svh
`include "block_transfer_receiver_ring_macros.svh"

module btrr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [btrr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);
  import btrr_pkg::*;

  logic is_ack, is_empty_read, stalled;

  assign is_ack        = m_axis_tvalid && (m_axis_tuser == KIND_ACK);
  assign is_empty_read = m_axis_tvalid && (m_axis_tuser == KIND_READ) && !m_axis_tdata[9];
  assign stalled       = m_axis_tvalid && !m_axis_tready;

  `BTRR_ASSERT_NXT(a_out_hold, stalled, m_axis_tvalid, "result item dropped while stalled")
  `BTRR_ASSERT_NXT(a_out_stable, stalled, $stable({m_axis_tuser, m_axis_tdata}), "result changed")
  `BTRR_ASSERT_IMP(a_ack_clean, is_ack, m_axis_tdata[9:1] == '0, "ack carries read fields")
  `BTRR_ASSERT_IMP(a_empty_read, is_empty_read, m_axis_tdata == '0, "empty read with byte or fill")

endmodule

bind block_transfer_receiver_ring btrr_checker u_btrr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
